FILE: rtl/emkv_pkg.sv
// Shared types and constants of the exact-match key/value table.
package emkv_pkg;

    // Width of the value carried on the ports and along the cell chain.
    localparam int VAL_W = 64;
    localparam int KEY_W = 64;

    // Widths of the configuration registers and the result count.
    localparam int KEY_WORDS_W   = 2;
    localparam int VALUE_BYTES_W = 4;
    localparam int LIMIT_W       = 7;
    localparam int COUNT_OUT_W   = 7;
    localparam int CFG_DATA_W    = 7;
    localparam int CFG_INDEX_W   = 2;
    localparam int STATUS_W      = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORDS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VALUE_BYTES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_LIMIT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [KEY_WORDS_W-1:0]   KEY_WORDS_RST   = 2'd2;
    localparam logic [VALUE_BYTES_W-1:0] VALUE_BYTES_RST = 4'd8;
    localparam logic [LIMIT_W-1:0]       ENTRY_LIMIT_RST = 7'd64;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_ENTRY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_RESOURCE = 2'd2;

    // Default sizes of the table.
    localparam int DEF_ENTRIES    = 64;
    localparam int DEF_KEY_BITS   = 64;
    localparam int DEF_VALUE_BITS = 64;

    // Operation of one request.
    typedef enum logic [1:0] {
        KIND_GET    = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_ERASE  = 2'd3
    } emkv_kind_t;

    // Token that walks down the chain, one cell per cycle.
    typedef struct packed {
        logic             act;
        logic             hit;
        logic             resv;
        logic [VAL_W-1:0] value;
    } emkv_tok_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        emkv_kind_t kind;
        logic       finish;
        logic       commit;
        logic       clear_all;
    } emkv_ctl_t;

endpackage

FILE: rtl/exact_match_key_value_table_top.sv
// Top level of the exact-match key/value table: sequencer, registers and cell chain.
//
// Requests enter on the input channel (in_valid, in_stall) with a kind (get, add,
// remove, erase), a key and a value. Each request yields one result on the output
// channel (out_valid, out_stall): a status, the value read by a get, and the number
// of valid entries after the request. The configuration port (cfg_valid, cfg_ready,
// cfg_index, cfg_data) sets the compared key words, the value bytes and the entry
// limit; it is always ready. The user must write it only while the table is idle;
// the block does not enforce this. A request is handled by a token that walks the
// row of ENTRIES cells, one cell per cycle. The first matching cell serves it and
// the first free cell reserves itself for an insert, so the lowest slot wins in both
// cases. When the token leaves the chain, the sequencer decides the status and
// commits or drops the reservation. The token passes launch_reg, the cells and
// end_tok_reg before the result is registered, and the next request is taken only
// after that, so one request at a time walks the chain, whose length sets the rate.
// The output register parts the two sides: a new request may be taken while a
// result waits. A finished request whose result cannot yet be registered, because
// the receiver stalls, is held at the end of the chain until the output frees up.
// Reset clears all valid marks, the entry count, the configuration (two key words,
// eight value bytes, limit 64) and both channels.
module exact_match_key_value_table_top
    import emkv_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Request channel.
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             kind,
    input  logic [KEY_W-1:0]       key,
    input  logic [VAL_W-1:0]       value,
    // Result channel.
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STATUS_W-1:0]    status,
    output logic [VAL_W-1:0]       value_out,
    output logic [COUNT_OUT_W-1:0] entry_count,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // The count must hold ENTRIES itself; compares run at the wider of it and the limit.
    localparam int CNT_W = (ENTRIES > 1) ? $clog2(ENTRIES + 1) : 1;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Configuration registers.
    logic [KEY_WORDS_W-1:0]   key_words_reg;
    logic [VALUE_BYTES_W-1:0] value_bytes_reg;
    logic [LIMIT_W-1:0]       entry_limit_reg;

    // Request held for the whole walk down the chain.
    emkv_kind_t              kind_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [VALUE_BITS-1:0]   value_reg;

    // Sequencer state.
    logic                    busy_reg;
    logic                    busy_next;
    logic                    launch_reg;
    logic                    pending_reg;
    logic                    pending_next;
    emkv_tok_t               end_tok_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    // Output register.
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [STATUS_W-1:0]     status_reg;
    logic [STATUS_W-1:0]     status_next;
    logic [VAL_W-1:0]        value_out_reg;
    logic [VAL_W-1:0]        value_out_next;

    logic                    in_take;
    logic                    fin;
    logic                    full;
    logic [CMP_W-1:0]        limit_eff;
    logic [VALUE_BYTES_W-1:0] byte_count;
    logic [VAL_W-1:0]        vmask_full;
    logic [VALUE_BITS-1:0]   val_mask;
    logic [KEY_BITS-1:0]     cmp_mask;
    emkv_ctl_t               ctl;
    emkv_tok_t               tok_chain [ENTRIES+1];

    assign in_take   = in_valid && !busy_reg;
    assign in_stall  = busy_reg;
    assign cfg_ready = 1'b1;

    // Masks that follow from the configuration.
    always_comb
    begin
        byte_count = (value_bytes_reg > VALUE_BYTES_W'(8)) ? VALUE_BYTES_W'(8)
                                                          : value_bytes_reg;
        for (int j = 0; j < 8; j++)
        begin
            vmask_full[8*j +: 8] = (VALUE_BYTES_W'(j) < byte_count) ? 8'hFF : 8'h00;
        end
        val_mask = vmask_full[VALUE_BITS-1:0];
        cmp_mask = (key_words_reg <= KEY_WORDS_W'(1)) ? KEY_BITS'(32'hFFFF_FFFF) : '1;

        limit_eff = (CMP_W'(entry_limit_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                               : CMP_W'(entry_limit_reg);
        full      = CMP_W'(count_reg) >= limit_eff;
    end

    // End of the walk: decide the result once the output register is free.
    always_comb
    begin
        fin = pending_reg && (!out_valid_reg || !out_stall);

        ctl.kind      = kind_reg;
        ctl.finish    = fin;
        ctl.commit    = fin && (kind_reg == KIND_ADD) && !end_tok_reg.hit
                        && end_tok_reg.resv && !full;
        ctl.clear_all = fin && (kind_reg == KIND_ERASE);

        status_next    = status_reg;
        value_out_next = value_out_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (fin)
        begin
            out_valid_next = 1'b1;
            status_next    = STATUS_OK;
            value_out_next = '0;
            unique case (kind_reg)
                KIND_GET:
                begin
                    if (end_tok_reg.hit)
                    begin
                        value_out_next = end_tok_reg.value;
                    end
                    else
                    begin
                        status_next = STATUS_NO_ENTRY;
                    end
                end
                KIND_ADD:
                begin
                    if (ctl.commit)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if (!end_tok_reg.hit)
                    begin
                        // The limit is reached or no slot is free.
                        status_next = STATUS_NO_RESOURCE;
                    end
                end
                KIND_REMOVE:
                begin
                    if (end_tok_reg.hit && (count_reg != '0))
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                KIND_ERASE:
                begin
                    count_next = '0;
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end

        pending_next = (pending_reg && !fin) || tok_chain[ENTRIES].act;
        busy_next    = (busy_reg && !fin) || in_take;
    end

    // The token enters the first cell in the cycle after the request is taken.
    assign tok_chain[0] = {launch_reg, 1'b0, 1'b0, {VAL_W{1'b0}}};

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        emkv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .req_key   (key_reg),
            .req_value (value_reg),
            .cmp_mask  (cmp_mask),
            .val_mask  (val_mask),
            .tok_in    (tok_chain[i]),
            .tok_out   (tok_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_words_reg   <= KEY_WORDS_RST;
            value_bytes_reg <= VALUE_BYTES_RST;
            entry_limit_reg <= ENTRY_LIMIT_RST;
            busy_reg        <= 1'b0;
            launch_reg      <= 1'b0;
            pending_reg     <= 1'b0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_KEY_WORDS:   key_words_reg   <= cfg_data[KEY_WORDS_W-1:0];
                    CFG_VALUE_BYTES: value_bytes_reg <= cfg_data[VALUE_BYTES_W-1:0];
                    CFG_ENTRY_LIMIT: entry_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:
                    begin
                        key_words_reg <= key_words_reg;
                    end
                endcase
            end
            busy_reg      <= busy_next;
            launch_reg    <= in_take;
            pending_reg   <= pending_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg  <= emkv_kind_t'(kind);
            key_reg   <= key[KEY_BITS-1:0];
            value_reg <= value[VALUE_BITS-1:0];
        end
        if (tok_chain[ENTRIES].act)
        begin
            end_tok_reg <= tok_chain[ENTRIES];
        end
        status_reg    <= status_next;
        value_out_reg <= value_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value_out   = value_out_reg;
    assign entry_count = COUNT_OUT_W'(count_reg);

endmodule

FILE: rtl/emkv_cell.sv
// One table entry: valid mark, key and value, plus the token stage of the chain.
module emkv_cell
    import emkv_pkg::*;
#(
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  emkv_ctl_t             ctl,
    input  logic [KEY_BITS-1:0]   req_key,
    input  logic [VALUE_BITS-1:0] req_value,
    input  logic [KEY_BITS-1:0]   cmp_mask,
    input  logic [VALUE_BITS-1:0] val_mask,
    input  emkv_tok_t             tok_in,
    output emkv_tok_t             tok_out
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  resv_reg;
    logic                  resv_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    emkv_tok_t             tok_reg;
    emkv_tok_t             tok_next;
    logic                  match;
    logic                  take;
    logic                  claim;

    always_comb
    begin
        match = valid_reg && (((key_reg ^ req_key) & cmp_mask) == '0);
        // The first matching cell serves the request; later matches see hit set.
        take  = tok_in.act && !tok_in.hit && match;
        // The first free cell reserves itself for a possible insert.
        claim = tok_in.act && !tok_in.resv && !valid_reg && (ctl.kind == KIND_ADD);

        tok_next = tok_in;
        if (take)
        begin
            tok_next.hit = 1'b1;
            if (ctl.kind == KIND_GET)
            begin
                tok_next.value = VAL_W'(value_reg & val_mask);
            end
        end
        if (claim)
        begin
            tok_next.resv = 1'b1;
        end

        priority if (ctl.clear_all)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.commit && resv_reg)
        begin
            valid_next = 1'b1;
        end
        else if (take && (ctl.kind == KIND_REMOVE))
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end

        priority if (ctl.finish)
        begin
            resv_next = 1'b0;
        end
        else if (claim)
        begin
            resv_next = 1'b1;
        end
        else
        begin
            resv_next = resv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            resv_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            resv_reg  <= resv_next;
            tok_reg   <= tok_next;
        end
    end

    // Entry payload: written when a free cell reserves itself; an add hit merges value bytes.
    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            key_reg   <= req_key;
            value_reg <= req_value & val_mask;
        end
        else if (take && (ctl.kind == KIND_ADD))
        begin
            value_reg <= (value_reg & ~val_mask) | (req_value & val_mask);
        end
    end

    assign tok_out = tok_reg;

endmodule
